// ===== sv/mhm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the masked histogram matching block: sizes, item and head types,
// and the state encoding of the back end. No dependencies.
package mhm_pkg;

  localparam int CHANNELS          = 3;
  localparam int BINS              = 256;
  localparam int PIX_W             = 8;
  localparam int BIN_IDX_W         = $clog2(BINS);
  localparam int BIN_W             = 21;
  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};
  localparam int MAX_REGION_PIXELS = 1048576;
  // Every cumulative sum is bounded by the number of pixels counted in a pass.
  localparam int CDF_W             = $clog2(MAX_REGION_PIXELS + 1);
  localparam int PROD_W            = 2 * CDF_W;
  localparam int PA_W              = $clog2(BINS + 1);
  localparam int CH_W              = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CHANNELS-1:0][PIX_W-1:0] pix_vec_t;

  typedef enum logic [1:0] {
    KIND_GATHER,
    KIND_GATHER_LAST,
    KIND_REPAINT
  } mhm_kind_t;

  typedef struct packed {
    mhm_kind_t kind;
    logic      masked;
    logic      last;
    pix_vec_t  src;
    pix_vec_t  tgt;
  } mhm_item_t;

  typedef struct packed {
    logic      valid;
    mhm_item_t item;
  } mhm_head_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GATHER_WR,
    ST_REPAINT_OUT,
    ST_PREFIX,
    ST_MATCH_RD,
    ST_MATCH_MUL,
    ST_MATCH_CMP
  } mhm_state_t;

endpackage

// ===== sv/mhm_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts pixel transactions, classifies them and keeps them in a
// short queue for the back end. Depends on mhm_pkg.
module mhm_front import mhm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] src_c0,
  input  logic [7:0] src_c1,
  input  logic [7:0] src_c2,
  input  logic [7:0] tgt_c0,
  input  logic [7:0] tgt_c1,
  input  logic [7:0] tgt_c2,
  input  logic [7:0] mask_byte,
  input  logic       last_pixel,
  input  logic       hold,
  input  logic       pop,
  output mhm_head_t  head
);

  mhm_item_t         queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  mhm_item_t         item_in;
  logic              accept;
  logic              take;

  always_comb begin
    item_in.masked = |mask_byte;
    item_in.last   = last_pixel;
    item_in.src    = {src_c2, src_c1, src_c0};
    item_in.tgt    = {tgt_c2, tgt_c1, tgt_c0};
    if (mode) begin
      item_in.kind = KIND_REPAINT;
    end else if (last_pixel) begin
      item_in.kind = KIND_GATHER_LAST;
    end else begin
      item_in.kind = KIND_GATHER;
    end
  end

  assign in_stall   = hold || (count == QCNT_W'(QUEUE_DEPTH));
  assign accept     = in_valid && !in_stall;
  assign take       = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = queue[rptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        wptr <= wptr + 1'b1;
      end
      if (take) begin
        rptr <= rptr + 1'b1;
      end
      if (accept && !take) begin
        count <= count + 1'b1;
      end else if (take && !accept) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/mhm_back.sv =====
`timescale 1ns / 1ps
// Back end: histogram updates, table build with clearing, and repaint lookup
// with the result register. Depends on mhm_pkg.
module mhm_back import mhm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  mhm_head_t  head,
  output logic       pop,
  output logic       clearing,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_c0,
  output logic [7:0] out_c1,
  output logic [7:0] out_c2,
  output logic       remapped,
  output logic       end_of_pass
);

  // Histogram and remap table memories, one of each per channel; the two CDF memories are shared.
  logic [BIN_W-1:0]     src_hist [CHANNELS][BINS];
  logic [BIN_W-1:0]     tgt_hist [CHANNELS][BINS];
  logic [PIX_W-1:0]     remap    [CHANNELS][BINS];
  logic [CDF_W-1:0]     scdf_mem [BINS];
  logic [CDF_W-1:0]     tcdf_mem [BINS];

  logic [BIN_W-1:0]     src_rd [CHANNELS];
  logic [BIN_W-1:0]     tgt_rd [CHANNELS];
  logic [PIX_W-1:0]     tbl_rd [CHANNELS];
  logic [CDF_W-1:0]     scdf_rd;
  logic [CDF_W-1:0]     tcdf_rd;

  mhm_state_t           state;
  mhm_state_t           state_next;
  logic [PA_W-1:0]      pa;
  logic [PA_W-1:0]      pa_m1;
  logic [CH_W-1:0]      ch;
  logic [CDF_W-1:0]     gathered;
  logic [CDF_W-1:0]     acc_s;
  logic [CDF_W-1:0]     acc_t;
  logic [CDF_W-1:0]     acc_s_next;
  logic [CDF_W-1:0]     acc_t_next;
  logic [BIN_IDX_W-1:0] v_idx;
  logic [BIN_IDX_W-1:0] b_idx;
  logic [PROD_W-1:0]    prod_l;
  logic [PROD_W-1:0]    prod_r;
  pix_vec_t             src_h;
  pix_vec_t             tgt_h;
  logic                 masked_h;
  logic                 last_h;
  pix_vec_t             out_r;

  logic                 hit;
  logic                 take_step;
  logic                 chan_done;
  logic                 load_out;
  logic [CHANNELS-1:0]  hist_we;
  logic [BIN_IDX_W-1:0] waddr_s [CHANNELS];
  logic [BIN_IDX_W-1:0] waddr_t [CHANNELS];
  logic [BIN_W-1:0]     wdata_s [CHANNELS];
  logic [BIN_W-1:0]     wdata_t [CHANNELS];
  logic [BIN_IDX_W-1:0] raddr_s [CHANNELS];
  logic [BIN_IDX_W-1:0] raddr_t [CHANNELS];
  logic                 cdf_we;
  logic [CHANNELS-1:0]  tbl_we;
  logic [CDF_W-1:0]     snum;
  logic [CDF_W-1:0]     tnum;
  logic [CDF_W-1:0]     sden;
  logic [CDF_W-1:0]     tden;

  assign pa_m1      = pa - 1'b1;
  assign hit        = head.item.masked && (gathered < CDF_W'(MAX_REGION_PIXELS));
  assign take_step  = (prod_l >= prod_r) || (b_idx == BIN_IDX_W'(BINS - 1));
  assign chan_done  = take_step && (v_idx == BIN_IDX_W'(BINS - 1));
  assign load_out   = (state == ST_REPAINT_OUT) && (!out_valid || !out_stall);
  assign acc_s_next = acc_s + CDF_W'(src_rd[ch]);
  assign acc_t_next = acc_t + CDF_W'(tgt_rd[ch]);

  // A zero total makes the whole CDF zero over a denominator of one.
  assign snum = (acc_s == '0) ? '0 : scdf_rd;
  assign tnum = (acc_t == '0) ? '0 : tcdf_rd;
  assign sden = (acc_s == '0) ? CDF_W'(1) : acc_s;
  assign tden = (acc_t == '0) ? CDF_W'(1) : acc_t;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (pa == PA_W'(BINS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head.valid) begin
          unique case (head.item.kind)
            KIND_GATHER:      state_next = hit ? ST_GATHER_WR : ST_IDLE;
            KIND_GATHER_LAST: state_next = hit ? ST_GATHER_WR : ST_PREFIX;
            KIND_REPAINT:     state_next = ST_REPAINT_OUT;
            default:          state_next = ST_IDLE;
          endcase
        end
      end
      ST_GATHER_WR:   state_next = last_h ? ST_PREFIX : ST_IDLE;
      ST_REPAINT_OUT: state_next = load_out ? ST_IDLE : ST_REPAINT_OUT;
      ST_PREFIX: begin
        if (pa == PA_W'(BINS)) begin
          state_next = ST_MATCH_RD;
        end
      end
      ST_MATCH_RD:  state_next = ST_MATCH_MUL;
      ST_MATCH_MUL: state_next = ST_MATCH_CMP;
      ST_MATCH_CMP: begin
        if (chan_done) begin
          state_next = (ch == CH_W'(CHANNELS - 1)) ? ST_IDLE : ST_PREFIX;
        end else begin
          state_next = ST_MATCH_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == ST_IDLE) && head.valid;
    clearing = (state == ST_CLEAR);
    cdf_we   = (state == ST_PREFIX) && (pa != '0);
    for (int c = 0; c < CHANNELS; c++) begin
      raddr_s[c] = (state == ST_IDLE) ? head.item.src[c] : pa[BIN_IDX_W-1:0];
      raddr_t[c] = (state == ST_IDLE) ? head.item.tgt[c] : pa[BIN_IDX_W-1:0];
      tbl_we[c]  = (state == ST_MATCH_CMP) && take_step && (ch == CH_W'(c));
      hist_we[c] = 1'b0;
      waddr_s[c] = pa[BIN_IDX_W-1:0];
      waddr_t[c] = pa[BIN_IDX_W-1:0];
      wdata_s[c] = '0;
      wdata_t[c] = '0;
      unique case (state)
        ST_GATHER_WR: begin
          hist_we[c] = 1'b1;
          waddr_s[c] = src_h[c];
          waddr_t[c] = tgt_h[c];
          wdata_s[c] = (src_rd[c] < BIN_MAX) ? src_rd[c] + 1'b1 : src_rd[c];
          wdata_t[c] = (tgt_rd[c] < BIN_MAX) ? tgt_rd[c] + 1'b1 : tgt_rd[c];
        end
        ST_CLEAR: begin
          hist_we[c] = 1'b1;
        end
        ST_PREFIX: begin
          hist_we[c] = (pa != '0) && (ch == CH_W'(c));
          waddr_s[c] = pa_m1[BIN_IDX_W-1:0];
          waddr_t[c] = pa_m1[BIN_IDX_W-1:0];
        end
        default: begin
          hist_we[c] = 1'b0;
        end
      endcase
    end
  end

  // Memories: one write and one registered read per array each cycle.
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (hist_we[c]) begin
        src_hist[c][waddr_s[c]] <= wdata_s[c];
        tgt_hist[c][waddr_t[c]] <= wdata_t[c];
      end
      src_rd[c] <= src_hist[c][raddr_s[c]];
      tgt_rd[c] <= tgt_hist[c][raddr_t[c]];
      if (tbl_we[c]) begin
        remap[c][v_idx] <= b_idx;
      end
      if (pop) begin
        tbl_rd[c] <= remap[c][head.item.tgt[c]];
      end
    end
    if (cdf_we) begin
      scdf_mem[pa_m1[BIN_IDX_W-1:0]] <= acc_s_next;
      tcdf_mem[pa_m1[BIN_IDX_W-1:0]] <= acc_t_next;
    end
    scdf_rd <= scdf_mem[b_idx];
    tcdf_rd <= tcdf_mem[v_idx];
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (pop) begin
      src_h    <= head.item.src;
      tgt_h    <= head.item.tgt;
      masked_h <= head.item.masked;
      last_h   <= head.item.last;
    end
    if (state == ST_PREFIX && pa != '0) begin
      acc_s <= acc_s_next;
      acc_t <= acc_t_next;
    end
    if (state_next == ST_PREFIX && state != ST_PREFIX) begin
      acc_s <= '0;
      acc_t <= '0;
    end
    if (state == ST_PREFIX) begin
      v_idx <= '0;
      b_idx <= '0;
    end else if (state == ST_MATCH_CMP) begin
      if (take_step) begin
        v_idx <= v_idx + 1'b1;
      end else begin
        b_idx <= b_idx + 1'b1;
      end
    end
    if (state == ST_MATCH_MUL) begin
      prod_l <= PROD_W'(snum) * PROD_W'(tden);
      prod_r <= PROD_W'(tnum) * PROD_W'(sden);
    end
    if (load_out) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_r[c] <= masked_h ? tbl_rd[c] : tgt_h[c];
      end
      remapped    <= masked_h;
      end_of_pass <= last_h;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      pa        <= '0;
      ch        <= '0;
      gathered  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next == ST_PREFIX && state != ST_PREFIX) begin
        pa <= '0;
        ch <= (state == ST_MATCH_CMP) ? ch + 1'b1 : '0;
      end else if (state == ST_CLEAR || state == ST_PREFIX) begin
        pa <= pa + 1'b1;
      end
      if (state == ST_GATHER_WR) begin
        gathered <= gathered + 1'b1;
      end else if (state == ST_MATCH_CMP && state_next == ST_IDLE) begin
        gathered <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_c0 = out_r[0];
  assign out_c1 = out_r[1];
  assign out_c2 = out_r[2];

endmodule

// ===== sv/masked_histogram_matching.sv =====
`timescale 1ns / 1ps
// Masked histogram matching, top level. Depends on mhm_pkg, mhm_front, mhm_back.
// Back-end steps: a masked gathering transaction is popped, then written to the histograms; an unmasked
// one is only popped; a repaint one is popped with its table read, then registered once the output is free.
// A last gathering transaction starts the table build: per channel a prefix-sum pass over the bins
// and merge steps of read, multiply and compare states (at most 511 steps), intake queued meanwhile.
// Reset is synchronous; a clearing pass over all bins then zeroes the histograms, intake stalled.
module masked_histogram_matching import mhm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [7:0] src_c0,
  input  logic [7:0] src_c1,
  input  logic [7:0] src_c2,
  input  logic [7:0] tgt_c0,
  input  logic [7:0] tgt_c1,
  input  logic [7:0] tgt_c2,
  input  logic [7:0] mask_byte,
  input  logic       last_pixel,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_c0,
  output logic [7:0] out_c1,
  output logic [7:0] out_c2,
  output logic       remapped,
  output logic       end_of_pass
);

  // The queue head, the pop strobe and the clearing flag couple the two halves;
  // the front stalls its input while the back end clears or its queue is full.
  mhm_head_t head;
  logic      pop;
  logic      clearing;

  mhm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .src_c0     (src_c0),
    .src_c1     (src_c1),
    .src_c2     (src_c2),
    .tgt_c0     (tgt_c0),
    .tgt_c1     (tgt_c1),
    .tgt_c2     (tgt_c2),
    .mask_byte  (mask_byte),
    .last_pixel (last_pixel),
    .hold       (clearing),
    .pop        (pop),
    .head       (head)
  );

  // The back end owns all histogram, CDF and table memories and the result
  // register, so a waiting result holds the back end and the front queue fills behind it.
  mhm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_c0      (out_c0),
    .out_c1      (out_c1),
    .out_c2      (out_c2),
    .remapped    (remapped),
    .end_of_pass (end_of_pass)
  );

endmodule

// ===== sim/masked_histogram_matching_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for masked_histogram_matching: a queue-fed driver, an
// in-line histogram and remap predictor, and a checking monitor. Depends on mhm_pkg.
module masked_histogram_matching_tb;
  import mhm_pkg::*;

  // One pixel transaction as it goes into the block.
  typedef struct {
    logic       mode;
    logic [7:0] src [3];
    logic [7:0] tgt [3];
    logic [7:0] mask;
    logic       last;
  } pixel_t;

  // One repainted pixel as it should come out of the block.
  typedef struct {
    logic [7:0] chan [3];
    logic       remapped;
    logic       end_of_pass;
  } repaint_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       mode;
  logic [7:0] src_c0, src_c1, src_c2;
  logic [7:0] tgt_c0, tgt_c1, tgt_c2;
  logic [7:0] mask_byte;
  logic       last_pixel;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_c0, out_c1, out_c2;
  logic       remapped;
  logic       end_of_pass;

  pixel_t   pending_pixels [$];
  repaint_t expected_repaints [$];
  int       error_count;
  int       accepted_count;
  int       stimulus_count;
  int       hold_cycles;
  bit       hold_done;

  // Predictor state: the histograms of the current gathering pass, the count of
  // masked pixels taken, and the remap tables of the last build.
  int unsigned src_hist [3][BINS];
  int unsigned tgt_hist [3][BINS];
  int unsigned region_count;
  logic [7:0]  remap_lut [3][BINS];

  masked_histogram_matching i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode),
    .src_c0(src_c0), .src_c1(src_c1), .src_c2(src_c2),
    .tgt_c0(tgt_c0), .tgt_c1(tgt_c1), .tgt_c2(tgt_c2),
    .mask_byte(mask_byte), .last_pixel(last_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_c0(out_c0), .out_c1(out_c1), .out_c2(out_c2),
    .remapped(remapped), .end_of_pass(end_of_pass)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idling rates follow how far the run has got: first the sender idles rarely and
  // the receiver often, then the other way round, then neither idles.
  function automatic int sender_idle_pct();
    if (accepted_count < 190) return 8;
    else if (accepted_count < 380) return 75;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (accepted_count < 190) return 75;
    else if (accepted_count < 380) return 8;
    return 0;
  endfunction

  // Builds the remap tables from the gathered histograms. The CDF test s/S >= t/T
  // is done exactly as s*T >= t*S, with an empty total counting as a zero CDF.
  function automatic void build_remap_tables();
    longint unsigned src_cdf [BINS];
    longint unsigned tgt_cdf [BINS];
    longint unsigned src_acc, tgt_acc, src_tot, tgt_tot, src_den, tgt_den;
    longint unsigned tgt_num, src_num;
    logic [7:0] pick;
    for (int c = 0; c < 3; c++) begin
      src_acc = 0;
      tgt_acc = 0;
      for (int b = 0; b < BINS; b++) begin
        src_acc += src_hist[c][b];
        tgt_acc += tgt_hist[c][b];
        src_cdf[b] = src_acc;
        tgt_cdf[b] = tgt_acc;
      end
      src_tot = src_cdf[BINS-1];
      tgt_tot = tgt_cdf[BINS-1];
      src_den = (src_tot != 0) ? src_tot : 1;
      tgt_den = (tgt_tot != 0) ? tgt_tot : 1;
      for (int v = 0; v < BINS; v++) begin
        tgt_num = (tgt_tot != 0) ? tgt_cdf[v] : 0;
        pick = 8'd255;
        for (int b = 0; b < BINS; b++) begin
          src_num = (src_tot != 0) ? src_cdf[b] : 0;
          if (src_num * tgt_den >= tgt_num * src_den) begin
            pick = b[7:0];
            break;
          end
        end
        remap_lut[c][v] = pick;
      end
      for (int b = 0; b < BINS; b++) begin
        src_hist[c][b] = 0;
        tgt_hist[c][b] = 0;
      end
    end
    region_count = 0;
  endfunction

  // Updates the predictor for one accepted pixel; a repaint pixel yields one result.
  function automatic void predict_pixel(pixel_t px);
    repaint_t r;
    if (px.mode == 1'b0) begin
      if (px.mask != 0 && region_count < MAX_REGION_PIXELS) begin
        for (int c = 0; c < 3; c++) begin
          if (src_hist[c][px.src[c]] < BIN_MAX) src_hist[c][px.src[c]]++;
          if (tgt_hist[c][px.tgt[c]] < BIN_MAX) tgt_hist[c][px.tgt[c]]++;
        end
        region_count++;
      end
      if (px.last) build_remap_tables();
    end else begin
      for (int c = 0; c < 3; c++)
        r.chan[c] = (px.mask != 0) ? remap_lut[c][px.tgt[c]] : px.tgt[c];
      r.remapped    = (px.mask != 0);
      r.end_of_pass = px.last;
      expected_repaints.push_back(r);
    end
  endfunction

  function automatic void queue_pixel(logic m, logic [7:0] msk, logic lst,
                                      logic [7:0] s0, logic [7:0] s1, logic [7:0] s2,
                                      logic [7:0] t0, logic [7:0] t1, logic [7:0] t2);
    pixel_t px;
    px.mode = m;
    px.mask = msk;
    px.last = lst;
    px.src[0] = s0; px.src[1] = s1; px.src[2] = s2;
    px.tgt[0] = t0; px.tgt[1] = t1; px.tgt[2] = t2;
    pending_pixels.push_back(px);
    stimulus_count++;
  endfunction

  // Channel value drawn either anywhere or from a band of random width above a base, so that the
  // histograms get both spread-out and lumpy shapes.
  function automatic logic [7:0] chan_value(int base, int spread);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'((base + $urandom_range(0, spread)) % 256);
  endfunction

  function automatic logic [7:0] random_mask(int zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return 8'd0;
    return 8'($urandom_range(1, 255));
  endfunction

  // A whole pass of random pixels; the last one carries the end-of-pass flag
  // unless a broken pass is wanted.
  function automatic void queue_pass(logic m, int len, bit close_pass, int zero_pct);
    int sb, tb, sw, tw;
    sb = $urandom_range(0, 255);
    tb = $urandom_range(0, 255);
    sw = $urandom_range(0, 255);
    tw = $urandom_range(0, 255);
    for (int i = 0; i < len; i++)
      queue_pixel(m, random_mask(zero_pct), close_pass && (i == len - 1),
                  chan_value(sb, sw), chan_value(sb, sw), chan_value(sb, sw),
                  chan_value(tb, tw), chan_value(tb, tw), chan_value(tb, tw));
  endfunction

  initial begin
    int pick;
    error_count    = 0;
    stimulus_count = 0;

    // Empty region: nothing masked, and the last pixel is unmasked too, so every
    // target value maps to bin 0.
    queue_pixel(1'b0, 8'd0, 1'b0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60);
    queue_pixel(1'b0, 8'd0, 1'b1, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    queue_pixel(1'b1, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd128, 8'd0);
    queue_pixel(1'b1, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd77, 8'd200, 8'd3);
    // Extremes: source at 255, target at 0, and the reverse; last pixel unmasked.
    queue_pixel(1'b0, 8'd1, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    queue_pixel(1'b0, 8'd128, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    queue_pixel(1'b0, 8'd255, 1'b0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd127);
    queue_pixel(1'b0, 8'd0, 1'b1, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5);
    queue_pixel(1'b1, 8'd1, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    queue_pixel(1'b1, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    queue_pixel(1'b1, 8'd64, 1'b0, 8'd0, 8'd0, 8'd0, 8'd127, 8'd128, 8'd1);
    queue_pixel(1'b1, 8'd0, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    // Single masked pixel pass, with a masked last pixel.
    queue_pixel(1'b0, 8'd2, 1'b1, 8'd100, 8'd200, 8'd50, 8'd150, 8'd25, 8'd250);
    queue_pixel(1'b1, 8'd9, 1'b0, 8'd0, 8'd0, 8'd0, 8'd149, 8'd25, 8'd251);
    queue_pixel(1'b1, 8'd9, 1'b1, 8'd0, 8'd0, 8'd0, 8'd150, 8'd24, 8'd250);

    // Random part: mostly whole gather-then-repaint sequences, plus noise.
    while (stimulus_count < 530) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        queue_pass(1'b0, ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40), 1'b1,
                   $urandom_range(0, 30));
        queue_pass(1'b1, $urandom_range(1, 40), 1'b1, $urandom_range(0, 40));
      end else if (pick < 85) begin
        // Gathering without a closing pixel: counts carry into the next pass.
        queue_pass(1'b0, $urandom_range(1, 10), 1'b0, 50);
      end else if (pick < 95) begin
        queue_pass(1'b1, $urandom_range(1, 12), ($urandom_range(0, 1) == 1), 50);
      end else begin
        queue_pass(1'b0, $urandom_range(1, 6), 1'b1, 100);
      end
    end
  end

  // Driver: offers the next pending pixel, holding it while the block stalls.
  always @(posedge clk) begin
    pixel_t px;
    if (rst) begin
      in_valid   <= 1'b0;
      mode       <= 1'b0;
      src_c0     <= '0; src_c1 <= '0; src_c2 <= '0;
      tgt_c0     <= '0; tgt_c1 <= '0; tgt_c2 <= '0;
      mask_byte  <= '0;
      last_pixel <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        px = pending_pixels.pop_front();
        in_valid   <= 1'b1;
        mode       <= px.mode;
        src_c0     <= px.src[0]; src_c1 <= px.src[1]; src_c2 <= px.src[2];
        tgt_c0     <= px.tgt[0]; tgt_c1 <= px.tgt[1]; tgt_c2 <= px.tgt[2];
        mask_byte  <= px.mask;
        last_pixel <= px.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Every accepted transaction goes through the predictor in acceptance order.
  always @(posedge clk) begin
    pixel_t px;
    if (!rst && in_valid && !in_stall) begin
      px.mode = mode;
      px.src[0] = src_c0; px.src[1] = src_c1; px.src[2] = src_c2;
      px.tgt[0] = tgt_c0; px.tgt[1] = tgt_c1; px.tgt[2] = tgt_c2;
      px.mask = mask_byte;
      px.last = last_pixel;
      predict_pixel(px);
      accepted_count <= accepted_count + 1;
    end
  end

  // Receiver stall. Once, early in the run, it holds off for a long stretch so
  // that the internal queue fills and the block has to stall its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && accepted_count >= 60) begin
      out_stall   <= 1'b1;
      hold_cycles <= 400;
      hold_done   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    repaint_t r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_repaints.size() == 0) begin
        $error("result with nothing expected: out_c0=%0d out_c1=%0d out_c2=%0d",
               out_c0, out_c1, out_c2);
        error_count++;
      end else begin
        r = expected_repaints.pop_front();
        if (out_c0 !== r.chan[0]) begin
          $error("out_c0: expected %0d, got %0d", r.chan[0], out_c0);
          error_count++;
        end
        if (out_c1 !== r.chan[1]) begin
          $error("out_c1: expected %0d, got %0d", r.chan[1], out_c1);
          error_count++;
        end
        if (out_c2 !== r.chan[2]) begin
          $error("out_c2: expected %0d, got %0d", r.chan[2], out_c2);
          error_count++;
        end
        if (remapped !== r.remapped) begin
          $error("remapped: expected %0d, got %0d", r.remapped, remapped);
          error_count++;
        end
        if (end_of_pass !== r.end_of_pass) begin
          $error("end_of_pass: expected %0d, got %0d", r.end_of_pass, end_of_pass);
          error_count++;
        end
      end
    end
  end

  // Reset once, then wait for the stimulus to drain and every result to arrive.
  // A trailing gathering pass can still be building tables, so the final wait
  // covers a full build.
  initial begin
    rst            = 1'b1;
    accepted_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait (stimulus_count > 0);
    while (pending_pixels.size() != 0 || in_valid) @(posedge clk);
    while (expected_repaints.size() != 0) @(posedge clk);
    repeat (6000) @(posedge clk);
    if (error_count == 0 && expected_repaints.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
